// ----- design/bptg_pkg.sv -----
// Shared types and constants for the burst pulse train generator.
package bptg_pkg;

  localparam int unsigned DELTA_W     = 16;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned OUT_CNT_W   = 16;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  localparam logic [CFG_INDEX_W-1:0] CFG_START_DELAY      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_PERIOD     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PULSES_PER_BURST = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BURST_TOTAL      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_BURST_GAP        = 3'd4;

  typedef struct packed {
    logic [31:0] start_delay;
    logic [31:0] pulse_period;
    logic [16:0] pulses_per_burst;
    logic [16:0] burst_total;
    logic [31:0] burst_gap;
  } bptg_cfg_t;

  localparam bptg_cfg_t CFG_RESET = '{
    start_delay:      32'd0,
    pulse_period:     32'd65536,
    pulses_per_burst: 17'h1FFFF,
    burst_total:      17'h1FFFF,
    burst_gap:        32'd0
  };

  typedef struct packed {
    logic                 pulse;
    logic                 finished;
    logic                 running;
    logic                 burst_complete;
    logic [OUT_CNT_W-1:0] burst_index;
    logic [OUT_CNT_W-1:0] pulse_index;
  } bptg_res_t;

endpackage

// ----- design/bptg_item_if.sv -----
// Input item channel: opcode and elapsed time.
interface bptg_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] delta_time;

  modport source (output valid, output opcode, output delta_time, input ready);
  modport sink (input valid, input opcode, input delta_time, output ready);
endinterface

// ----- design/bptg_result_if.sv -----
// Result channel: pulse flag, status and counters.
interface bptg_result_if;
  logic        valid;
  logic        ready;
  logic        pulse;
  logic        finished;
  logic        running;
  logic        burst_complete;
  logic [15:0] burst_index;
  logic [15:0] pulse_index;

  modport source (output valid, output pulse, output finished, output running,
                  output burst_complete, output burst_index, output pulse_index,
                  input ready);
  modport sink (input valid, input pulse, input finished, input running,
                input burst_complete, input burst_index, input pulse_index,
                output ready);
endinterface

// ----- design/bptg_cfg_if.sv -----
// Configuration write channel: register index and data.
interface bptg_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- design/bptg_cfg_regs.sv -----
// Configuration register file.
module bptg_cfg_regs (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [2:0]            wr_index,
  input  logic [31:0]           wr_data,
  output bptg_pkg::bptg_cfg_t   cfg
);
  import bptg_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr_en) begin
      case (wr_index)
        CFG_START_DELAY:      cfg.start_delay      <= wr_data;
        CFG_PULSE_PERIOD:     cfg.pulse_period     <= wr_data;
        CFG_PULSES_PER_BURST: cfg.pulses_per_burst <= wr_data[16:0];
        CFG_BURST_TOTAL:      cfg.burst_total      <= wr_data[16:0];
        CFG_BURST_GAP:        cfg.burst_gap        <= wr_data;
        default: ;
      endcase
    end
  end
endmodule

// ----- design/bptg_core.sv -----
// Generator state and the per-item update of timers and counters.
module bptg_core #(
  parameter int unsigned TIME_WIDTH  = 32,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  bptg_pkg::op_t        op,
  input  logic [15:0]          delta,
  input  bptg_pkg::bptg_cfg_t  cfg,
  output bptg_pkg::bptg_res_t  res
);
  import bptg_pkg::*;

  localparam int unsigned TW = TIME_WIDTH;
  localparam int unsigned CW = COUNT_WIDTH;
  // common width for time compares against the 32 bit registers
  localparam int unsigned XW = (TW > 32) ? TW : 32;
  // signed width for count compares against the 17 bit signed registers
  localparam int unsigned SW = ((CW > 17) ? CW : 17) + 2;

  logic          active, active_next;
  logic          done, done_next;
  logic [TW-1:0] elapsed, elapsed_next;
  logic [TW-1:0] period, period_next;
  logic [TW-1:0] gap, gap_next;
  logic [CW-1:0] burst_cnt, burst_cnt_next;
  logic [CW-1:0] pulse_cnt, pulse_cnt_next;
  logic          pulse;
  logic [TW-1:0] gap_sum, per_sum, pp_sat;

  logic [XW-1:0]        sd_x, pp_x, gap_x, tmax_x;
  logic signed [SW-1:0] ppb_s, bt_m1;
  logic                 ppb_neg, bt_neg;

  function automatic logic [TW-1:0] tadd(input logic [TW-1:0] t, input logic [15:0] d);
    logic [TW:0] s;
    s = {1'b0, t} + (TW+1)'(d);
    return s[TW] ? {TW{1'b1}} : s[TW-1:0];
  endfunction

  function automatic logic [CW-1:0] cinc(input logic [CW-1:0] c);
    return (c == {CW{1'b1}}) ? c : c + 1'b1;
  endfunction

  function automatic logic signed [SW-1:0] cext(input logic [CW-1:0] c);
    return $signed(SW'(c));
  endfunction

  // waiting out the gap: burst full and another burst still to come
  function automatic logic between(input logic [CW-1:0] pc, input logic [CW-1:0] bc,
                                   input logic pneg, input logic bneg,
                                   input logic signed [SW-1:0] ppb,
                                   input logic signed [SW-1:0] btm1);
    return !pneg && (cext(pc) >= ppb) && (bneg || (cext(bc) < btm1));
  endfunction

  assign sd_x    = XW'(cfg.start_delay);
  assign pp_x    = XW'(cfg.pulse_period);
  assign gap_x   = XW'(cfg.burst_gap);
  assign tmax_x  = XW'({TW{1'b1}});
  assign pp_sat  = (pp_x > tmax_x) ? {TW{1'b1}} : TW'(pp_x);
  assign ppb_s   = SW'($signed(cfg.pulses_per_burst));
  assign bt_m1   = SW'($signed(cfg.burst_total)) - SW'(1);
  assign ppb_neg = cfg.pulses_per_burst[16];
  assign bt_neg  = cfg.burst_total[16];

  always_comb begin
    active_next    = active;
    done_next      = done;
    elapsed_next   = elapsed;
    period_next    = period;
    gap_next       = gap;
    burst_cnt_next = burst_cnt;
    pulse_cnt_next = pulse_cnt;
    pulse          = 1'b0;
    gap_sum        = tadd(gap, delta);
    per_sum        = '0;
    case (op)
      OP_START: begin
        if (!active) begin
          elapsed_next   = '0;
          period_next    = pp_sat;
          gap_next       = '0;
          burst_cnt_next = '0;
          pulse_cnt_next = '0;
          done_next      = 1'b0;
        end
        active_next = 1'b1;
      end
      OP_STOP: begin
        active_next = 1'b0;
      end
      OP_TICK: begin
        if (active) begin
          elapsed_next = tadd(elapsed, delta);
          if (XW'(elapsed_next) > sd_x) begin
            if (between(pulse_cnt, burst_cnt, ppb_neg, bt_neg, ppb_s, bt_m1)) begin
              if (XW'(gap_sum) >= gap_x) begin
                burst_cnt_next = cinc(burst_cnt);
                gap_next       = '0;
                pulse_cnt_next = '0;
                period_next    = pp_sat;
              end else begin
                gap_next = gap_sum;
              end
            end
            if (ppb_neg || (cext(pulse_cnt_next) < ppb_s)) begin
              per_sum = tadd(period_next, delta);
              if (XW'(per_sum) > pp_x) begin
                period_next    = '0;
                pulse          = 1'b1;
                pulse_cnt_next = cinc(pulse_cnt_next);
              end else begin
                period_next = per_sum;
              end
            end
          end
          if (!bt_neg && (cext(burst_cnt_next) >= bt_m1) &&
              (cext(pulse_cnt_next) >= ppb_s)) begin
            done_next   = 1'b1;
            active_next = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      done      <= 1'b0;
      elapsed   <= '0;
      period    <= '0;
      gap       <= '0;
      burst_cnt <= '0;
      pulse_cnt <= '0;
    end else if (en) begin
      active    <= active_next;
      done      <= done_next;
      elapsed   <= elapsed_next;
      period    <= period_next;
      gap       <= gap_next;
      burst_cnt <= burst_cnt_next;
      pulse_cnt <= pulse_cnt_next;
    end
  end

  assign res.pulse          = pulse;
  assign res.finished       = done_next;
  assign res.running        = active_next;
  assign res.burst_complete = ppb_neg ||
                              between(pulse_cnt_next, burst_cnt_next, ppb_neg, bt_neg,
                                      ppb_s, bt_m1);
  assign res.burst_index    = OUT_CNT_W'(burst_cnt_next);
  assign res.pulse_index    = OUT_CNT_W'(pulse_cnt_next);
endmodule

// ----- design/burst_pulse_train_generator_unit.sv -----
// The input transaction is held in the input register, and its result in the result register.
// Throughput: one transaction per cycle while the result is not stalled; the state update is a single pass of
// adds and compares between the input register and the result register.
// Both stages hold while the result is stalled; the input is still taken if a stage is free.
// Reset (rst, synchronous): generator stopped, timers and counters zero,
// configuration registers back to their defaults, both stages empty.
module burst_pulse_train_generator_unit #(
  parameter int unsigned TIME_WIDTH  = 32,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input logic          clk,
  input logic          rst,
  bptg_item_if.sink    item,
  bptg_result_if.source result,
  bptg_cfg_if.sink     cfg
);
  import bptg_pkg::*;

  bptg_cfg_t   cfg_regs;
  bptg_res_t   core_res;
  bptg_res_t   res_q;
  logic        res_valid;
  logic        s1_valid;
  op_t         s1_op;
  logic [15:0] s1_delta;
  logic        advance;
  logic        item_take;

  assign advance   = !res_valid || result.ready;
  assign item.ready = !s1_valid || advance;
  assign item_take = item.valid && item.ready;
  assign cfg.ready = 1'b1;

  bptg_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_regs)
  );

  bptg_core #(
    .TIME_WIDTH  (TIME_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .en    (s1_valid && advance),
    .op    (s1_op),
    .delta (s1_delta),
    .cfg   (cfg_regs),
    .res   (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      s1_op    <= op_t'(item.opcode);
      s1_delta <= item.delta_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      res_q <= core_res;
    end
  end

  assign result.valid          = res_valid;
  assign result.pulse          = res_q.pulse;
  assign result.finished       = res_q.finished;
  assign result.running        = res_q.running;
  assign result.burst_complete = res_q.burst_complete;
  assign result.burst_index    = res_q.burst_index;
  assign result.pulse_index    = res_q.pulse_index;
endmodule

// ----- design/bptg_chk.sv -----
// Port-level checker for the burst pulse train generator, bound to the top level.
module bptg_chk (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic        pulse,
  input logic        finished,
  input logic        running,
  input logic [15:0] burst_index,
  input logic [15:0] pulse_index
);

  // a finished run has always stopped itself
  a_finished_stopped: assert property (@(posedge clk) disable iff (rst)
    res_valid && finished |-> !running)
    else $error("finished result shows generator running");

  // a pulse only leaves the generator running or just finished
  a_pulse_live: assert property (@(posedge clk) disable iff (rst)
    res_valid && pulse |-> running || finished)
    else $error("pulse from a stopped generator");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result transaction dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(pulse) && $stable(finished) && $stable(running)
                               && $stable(burst_index) && $stable(pulse_index))
    else $error("result payload changed while stalled");

endmodule

bind burst_pulse_train_generator_unit bptg_chk u_bptg_chk (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .pulse       (result.pulse),
  .finished    (result.finished),
  .running     (result.running),
  .burst_index (result.burst_index),
  .pulse_index (result.pulse_index)
);
